[hdl/array_insert_delete_engine_macros.svh]
// Assertion macros shared by the list engine modules.
// Needs i_clk and i_rst_n in the scope of every use.
`ifndef ARRAY_INSERT_DELETE_ENGINE_MACROS_SVH
`define ARRAY_INSERT_DELETE_ENGINE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define AIDE_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
// next-cycle implication
`define AIDE_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define AIDE_IMPLIES(lbl, pre, post, msg)
`define AIDE_NEXT(lbl, pre, post, msg)
`endif
`endif

[hdl/aide_pkg.sv]
// Shared types and constants of the list engine.
// Used by aide_front, aide_back and array_insert_delete_engine.
package aide_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = 7;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // request function codes
    typedef enum logic [2:0] {
        F_INS_FRONT = 3'd0,
        F_INS_END   = 3'd1,
        F_INS_POS   = 3'd2,
        F_DEL_FRONT = 3'd3,
        F_DEL_END   = 3'd4,
        F_DEL_POS   = 3'd5,
        F_DEL_VALUE = 3'd6,
        F_DISPLAY   = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_INSERT    = 2'd0,
        K_DELETE    = 2'd1,
        K_DEL_VALUE = 2'd2,
        K_DISPLAY   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        W_FRONT = 2'd0,
        W_END   = 2'd1,
        W_POS   = 2'd2
    } t_where;

    typedef struct packed {
        logic [2:0]         func;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic [5:0]         element_index;
        logic [6:0]         length;
        logic [6:0]         removed;
        logic               last;
    } t_out_beat;

    // classified request held in the queue
    typedef struct packed {
        t_kind              kind;
        t_where             where;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;

    // back-end sequencer states
    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_MOVE      = 5'b00010,
        S_FINAL     = 5'b00100,
        S_DISP_RD   = 5'b01000,
        S_DISP_WAIT = 5'b10000
    } t_state;

endpackage

[hdl/aide_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module aide_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port, read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/aide_front.sv]
// Front end: accepts request beats, decodes the function code and queues them.
// Depends on aide_pkg and array_insert_delete_engine_macros.svh.
`include "array_insert_delete_engine_macros.svh"
module aide_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  aide_pkg::t_in_beat   i_in_beat,
    output aide_pkg::t_queue_head o_head,
    input  logic                 i_pop
);

    aide_pkg::t_cmd                    r_q [aide_pkg::QDEPTH];
    logic [aide_pkg::QPTR_W-1:0]       r_wr;
    logic [aide_pkg::QPTR_W-1:0]       r_rd;
    logic [aide_pkg::QCNT_W-1:0]       r_cnt;
    aide_pkg::t_cmd                    cmd;
    logic                              push;

    assign o_in_stall = (r_cnt == aide_pkg::QCNT_W'(aide_pkg::QDEPTH));
    assign push       = i_in_valid && !o_in_stall;

    // classify the function code
    always_comb begin
        cmd.position = i_in_beat.position;
        cmd.value    = i_in_beat.value;
        case (aide_pkg::t_func'(i_in_beat.func))
            aide_pkg::F_INS_FRONT: begin
                cmd.kind = aide_pkg::K_INSERT;    cmd.where = aide_pkg::W_FRONT;
            end
            aide_pkg::F_INS_END: begin
                cmd.kind = aide_pkg::K_INSERT;    cmd.where = aide_pkg::W_END;
            end
            aide_pkg::F_INS_POS: begin
                cmd.kind = aide_pkg::K_INSERT;    cmd.where = aide_pkg::W_POS;
            end
            aide_pkg::F_DEL_FRONT: begin
                cmd.kind = aide_pkg::K_DELETE;    cmd.where = aide_pkg::W_FRONT;
            end
            aide_pkg::F_DEL_END: begin
                cmd.kind = aide_pkg::K_DELETE;    cmd.where = aide_pkg::W_END;
            end
            aide_pkg::F_DEL_POS: begin
                cmd.kind = aide_pkg::K_DELETE;    cmd.where = aide_pkg::W_POS;
            end
            aide_pkg::F_DEL_VALUE: begin
                cmd.kind = aide_pkg::K_DEL_VALUE; cmd.where = aide_pkg::W_FRONT;
            end
            default: begin
                cmd.kind = aide_pkg::K_DISPLAY;   cmd.where = aide_pkg::W_FRONT;
            end
        endcase
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rd];

    `AIDE_IMPLIES(a_pop_nonempty, i_pop, r_cnt != '0, "pop from empty queue")
    `AIDE_NEXT(a_push_grows, push && !i_pop, r_cnt == aide_pkg::QCNT_W'($past(r_cnt) + 1'b1), "fill count did not grow")
    `AIDE_NEXT(a_pop_shrinks, i_pop && !push, r_cnt == aide_pkg::QCNT_W'($past(r_cnt) - 1'b1), "fill count did not shrink")

endmodule

[hdl/aide_back.sv]
// Back end: sequencer that shifts, compacts and reads the entry memory,
// with the count register and the result register. Depends on aide_pkg,
// aide_ram and array_insert_delete_engine_macros.svh.
`include "array_insert_delete_engine_macros.svh"
module aide_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  aide_pkg::t_queue_head i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output aide_pkg::t_out_beat   o_out_beat
);

    localparam int IW = aide_pkg::IDX_W;
    localparam int CW = aide_pkg::CNT_W;

    aide_pkg::t_state    r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    aide_pkg::t_kind     r_kind, n_kind;
    logic [31:0]         r_value, n_value;
    logic [1:0]          r_status, n_status;
    logic [IW-1:0]       r_p, n_p;
    logic [IW-1:0]       r_rd_idx, n_rd_idx;
    logic [CW-1:0]       r_rd_left, n_rd_left;
    logic                r_pend, n_pend;
    logic [IW-1:0]       r_pend_idx, n_pend_idx;
    logic [CW-1:0]       r_wr_ptr, n_wr_ptr;
    logic                r_out_valid;
    aide_pkg::t_out_beat r_out;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [31:0]         ram_wdata;
    logic                ram_re;
    logic [IW-1:0]       ram_raddr;
    logic [31:0]         ram_rdata;

    logic                out_free;
    logic                out_load;
    aide_pkg::t_out_beat out_beat;
    logic [CW:0]         cnt_p1;
    logic [CW:0]         pos_x;
    logic [CW-1:0]       cnt_m1;
    logic [IW-1:0]       pos_m1;

    aide_ram #(
        .WIDTH (32),
        .DEPTH (aide_pkg::DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign cnt_p1   = {1'b0, r_count} + 1'b1;
    assign pos_x    = {1'b0, i_head.cmd.position};
    assign cnt_m1   = r_count - 1'b1;
    assign pos_m1   = IW'(i_head.cmd.position - 1'b1);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_kind     = r_kind;
        n_value    = r_value;
        n_status   = r_status;
        n_p        = r_p;
        n_rd_idx   = r_rd_idx;
        n_rd_left  = r_rd_left;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_wr_ptr   = r_wr_ptr;
        o_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = r_value;
        ram_re     = 1'b0;
        ram_raddr  = r_rd_idx;
        out_load   = 1'b0;
        out_beat   = '0;

        case (r_state)
            aide_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    o_pop    = 1'b1;
                    n_kind   = i_head.cmd.kind;
                    n_value  = i_head.cmd.value;
                    n_status = aide_pkg::ST_OK;
                    n_pend   = 1'b0;
                    n_state  = aide_pkg::S_FINAL;
                    case (i_head.cmd.kind)
                        aide_pkg::K_INSERT: begin
                            // slot for the new entry
                            case (i_head.cmd.where)
                                aide_pkg::W_FRONT: n_p = '0;
                                aide_pkg::W_END:   n_p = r_count[IW-1:0];
                                default:           n_p = pos_m1;
                            endcase
                            if (r_count == CW'(aide_pkg::DEPTH)) begin
                                n_status = aide_pkg::ST_FULL;
                            end else if (i_head.cmd.where == aide_pkg::W_POS &&
                                         (i_head.cmd.position == '0 || pos_x > cnt_p1)) begin
                                n_status = aide_pkg::ST_BADPOS;
                            end else begin
                                // move [p, count-1] up, top entry first
                                n_rd_idx  = cnt_m1[IW-1:0];
                                n_rd_left = r_count - CW'(n_p);
                                n_state   = aide_pkg::S_MOVE;
                            end
                        end
                        aide_pkg::K_DELETE: begin
                            case (i_head.cmd.where)
                                aide_pkg::W_FRONT: n_p = '0;
                                aide_pkg::W_END:   n_p = cnt_m1[IW-1:0];
                                default:           n_p = pos_m1;
                            endcase
                            if (r_count == '0) begin
                                n_status = aide_pkg::ST_EMPTY;
                            end else if (i_head.cmd.where == aide_pkg::W_POS &&
                                         (i_head.cmd.position == '0 ||
                                          i_head.cmd.position > r_count)) begin
                                n_status = aide_pkg::ST_BADPOS;
                            end else begin
                                // move [p+1, count-1] down, lowest entry first
                                n_rd_idx  = n_p + 1'b1;
                                n_rd_left = cnt_m1 - CW'(n_p);
                                n_state   = aide_pkg::S_MOVE;
                            end
                        end
                        aide_pkg::K_DEL_VALUE: begin
                            if (r_count == '0) begin
                                n_status = aide_pkg::ST_EMPTY;
                            end else begin
                                n_rd_idx  = '0;
                                n_rd_left = r_count;
                                n_wr_ptr  = '0;
                                n_state   = aide_pkg::S_MOVE;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_status = aide_pkg::ST_EMPTY;
                            end else begin
                                n_rd_idx = '0;
                                n_state  = aide_pkg::S_DISP_RD;
                            end
                        end
                    endcase
                end
            end

            aide_pkg::S_MOVE: begin
                // read side: one word per cycle
                n_pend = 1'b0;
                if (r_rd_left != '0) begin
                    ram_re     = 1'b1;
                    ram_raddr  = r_rd_idx;
                    n_rd_idx   = (r_kind == aide_pkg::K_INSERT) ? r_rd_idx - 1'b1
                                                                : r_rd_idx + 1'b1;
                    n_rd_left  = r_rd_left - 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx;
                end
                // write side: word read in the previous cycle
                if (r_pend) begin
                    ram_wdata = ram_rdata;
                    case (r_kind)
                        aide_pkg::K_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pend_idx + 1'b1;
                        end
                        aide_pkg::K_DELETE: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pend_idx - 1'b1;
                        end
                        default: begin
                            // keep only the non-matching words
                            if (ram_rdata != r_value) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_wr_ptr[IW-1:0];
                                n_wr_ptr  = r_wr_ptr + 1'b1;
                            end
                        end
                    endcase
                end
                if (r_rd_left == '0 && !r_pend) begin
                    n_state = aide_pkg::S_FINAL;
                end
            end

            aide_pkg::S_FINAL: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_beat.status = r_status;
                    out_beat.last   = 1'b1;
                    if (r_status == aide_pkg::ST_OK) begin
                        case (r_kind)
                            aide_pkg::K_INSERT: begin
                                ram_we    = 1'b1;
                                ram_waddr = r_p;
                                ram_wdata = r_value;
                                n_count   = r_count + 1'b1;
                            end
                            aide_pkg::K_DELETE: begin
                                n_count = cnt_m1;
                            end
                            aide_pkg::K_DEL_VALUE: begin
                                n_count          = r_wr_ptr;
                                out_beat.removed = r_count - r_wr_ptr;
                            end
                            default: begin
                                n_count = r_count;
                            end
                        endcase
                    end
                    out_beat.length = n_count;
                    n_state         = aide_pkg::S_IDLE;
                end
            end

            aide_pkg::S_DISP_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_rd_idx;
                n_state   = aide_pkg::S_DISP_WAIT;
            end

            aide_pkg::S_DISP_WAIT: begin
                if (out_free) begin
                    out_load               = 1'b1;
                    out_beat.status        = aide_pkg::ST_OK;
                    out_beat.element       = ram_rdata;
                    out_beat.element_index = 6'(r_rd_idx);
                    out_beat.length        = r_count;
                    out_beat.last          = (CW'(r_rd_idx) + 1'b1 == r_count);
                    if (out_beat.last) begin
                        n_state = aide_pkg::S_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                        n_state  = aide_pkg::S_DISP_RD;
                    end
                end
            end

            default: begin
                n_state = aide_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aide_pkg::S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_value    <= n_value;
        r_status   <= n_status;
        r_p        <= n_p;
        r_rd_idx   <= n_rd_idx;
        r_rd_left  <= n_rd_left;
        r_pend_idx <= n_pend_idx;
        r_wr_ptr   <= n_wr_ptr;
        if (out_load) begin
            r_out <= out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    `AIDE_IMPLIES(a_count_max, 1'b1, r_count <= CW'(aide_pkg::DEPTH), "entry count above depth")
    `AIDE_IMPLIES(a_out_hold, r_out_valid && i_out_stall, !out_load, "stalled result overwritten")
    `AIDE_IMPLIES(a_compact_ptr, r_state == aide_pkg::S_MOVE && r_kind == aide_pkg::K_DEL_VALUE, r_wr_ptr <= r_count, "compaction pointer past count")
    `AIDE_NEXT(a_pend_follows, r_state == aide_pkg::S_MOVE && r_rd_left != '0, r_pend, "read word not tracked")

endmodule

[hdl/array_insert_delete_engine.sv]
// Packed list engine: insert, delete, delete-by-value and display on up to
// DEPTH signed 32-bit entries. Top level; depends on aide_pkg, aide_front, aide_back.
//
// Usage:
//   Request channel: i_in_valid / o_in_stall carry one request beat
//   (func, position, value). A two-entry queue takes beats while the back end
//   works, so o_in_stall rises only when that queue is full.
//   Result channel: o_out_valid / i_out_stall carry result beats from one
//   output register. Every request gives one beat with last set, except a
//   display of a non-empty list, which gives one beat per entry, the final
//   one with last set.
//   A request that fails its checks moves no word. Inserts and deletes move
//   the entries above the position and delete-by-value reads the whole list.
//   Display handles each entry in turn: read it, then load the result
//   register. The entry RAM has a single port pair, so words move one at a
//   time.
//   Reset (i_rst_n low, synchronous) empties the list and the queue and drops
//   o_out_valid; the entry RAM is not cleared.
//   While i_out_stall is high a valid result beat holds and no other loads;
//   word moves go on, and requests keep entering the queue until it fills.
module array_insert_delete_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  aide_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output aide_pkg::t_out_beat o_out_beat
);

    aide_pkg::t_queue_head head;
    logic                  pop;

    // request decode and queue
    aide_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_head     (head),
        .i_pop      (pop)
    );

    // execution and result register
    aide_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule
